// ----- hw/rtl/wiit_pkg.sv -----
// shared types and constants for the world inverse inertia transform
package wiit_pkg;

   localparam int DIV_BITS = 31;
   localparam int ROT_LAT  = DIV_BITS + 7;
   localparam int MAT_LAT  = 5;
   localparam int PIPE_LAT = ROT_LAT + MAT_LAT;
   localparam int DET_LAT  = 5;

   localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

   typedef struct packed {
      logic signed [31:0] quat_w;
      logic signed [31:0] quat_x;
      logic signed [31:0] quat_y;
      logic signed [31:0] quat_z;
      logic signed [31:0] local_xx;
      logic signed [31:0] local_xy;
      logic signed [31:0] local_xz;
      logic signed [31:0] local_yy;
      logic signed [31:0] local_yz;
      logic signed [31:0] local_zz;
   } wiit_req_type;

   typedef struct packed {
      logic signed [31:0] world_xx;
      logic signed [31:0] world_xy;
      logic signed [31:0] world_xz;
      logic signed [31:0] world_yy;
      logic signed [31:0] world_yz;
      logic signed [31:0] world_zz;
      logic               singular_flag;
   } wiit_rsp_type;

   typedef struct packed {
      logic signed [31:0] xx;
      logic signed [31:0] xy;
      logic signed [31:0] xz;
      logic signed [31:0] yy;
      logic signed [31:0] yz;
      logic signed [31:0] zz;
   } wiit_tensor_type;

endpackage

// ----- hw/rtl/wiit_rot.sv -----
// quaternion to rotation matrix pipeline with per-element restoring dividers
module wiit_rot (
   input  logic                   clock,
   input  logic                   adv,
   input  wiit_pkg::wiit_req_type req,
   output logic signed [31:0]     rot [9]
);

   logic signed [63:0] s1_prod_in [10];
   logic signed [63:0] s1_prod_ff [10];
   logic signed [61:0] s2_qtr_in [10];
   logic signed [61:0] s2_qtr_ff [10];
   logic [62:0]        s3_n_in;
   logic [62:0]        s3_n_ff;
   logic signed [63:0] s3_num_in [9];
   logic signed [63:0] s3_num_ff [9];
   logic [62:0]        s4_n_in;
   logic [62:0]        s4_n_ff;
   logic [4:0]         s4_k_in;
   logic [4:0]         s4_k_ff;
   logic [62:0]        s4_mag_in [9];
   logic [62:0]        s4_mag_ff [9];
   logic [8:0]         s4_neg_in;
   logic [8:0]         s4_neg_ff;
   logic [32:0]        s5_mag_in [9];
   logic [32:0]        s5_mag_ff [9];
   logic [31:0]        s5_den_in;
   logic [31:0]        s5_den_ff;
   logic [8:0]         s5_neg_in;
   logic [8:0]         s5_neg_ff;
   logic               s5_zero_in;
   logic               s5_zero_ff;

   logic [63:0]               dv_rem_in   [wiit_pkg::DIV_BITS+1][9];
   logic [63:0]               dv_rem_ff   [wiit_pkg::DIV_BITS+1][9];
   logic [wiit_pkg::DIV_BITS-1:0] dv_quo_in [wiit_pkg::DIV_BITS+1][9];
   logic [wiit_pkg::DIV_BITS-1:0] dv_quo_ff [wiit_pkg::DIV_BITS+1][9];
   logic [31:0]               dv_den_in   [wiit_pkg::DIV_BITS+1];
   logic [31:0]               dv_den_ff   [wiit_pkg::DIV_BITS+1];
   logic [8:0]                dv_neg_in   [wiit_pkg::DIV_BITS+1];
   logic [8:0]                dv_neg_ff   [wiit_pkg::DIV_BITS+1];
   logic [8:0]                dv_clamp_in [wiit_pkg::DIV_BITS+1];
   logic [8:0]                dv_clamp_ff [wiit_pkg::DIV_BITS+1];
   logic                      dv_zero_in  [wiit_pkg::DIV_BITS+1];
   logic                      dv_zero_ff  [wiit_pkg::DIV_BITS+1];

   logic signed [31:0] rot_in [9];
   logic signed [31:0] rot_ff [9];

   // bit length of a 31-bit value by binary search
   function automatic logic [4:0] bitlen31(input logic [30:0] v);
      logic [31:0] t;
      logic [4:0]  r;
      t = {1'b0, v};
      r = '0;
      if (t[31:16] != '0) begin
         r = r + 5'd16;
         t = t >> 16;
      end
      if (t[15:8] != '0) begin
         r = r + 5'd8;
         t = t >> 8;
      end
      if (t[7:4] != '0) begin
         r = r + 5'd4;
         t = t >> 4;
      end
      if (t[3:2] != '0) begin
         r = r + 5'd2;
         t = t >> 2;
      end
      if (t[1]) begin
         r = r + 5'd1;
         t = t >> 1;
      end
      return r + {4'b0, t[0]};
   endfunction

   always_comb begin
      logic signed [31:0] qw, qx, qy, qz;
      logic signed [63:0] qtmp;
      logic signed [63:0] qe [10];
      logic signed [63:0] n64;
      logic signed [63:0] mag64;
      logic [62:0]        shv;
      logic [62:0]        nsh;
      logic [63:0]        lim;
      logic [63:0]        trial;
      logic               ge;
      logic [wiit_pkg::DIV_BITS-1:0] rmag;
      logic signed [31:0] rsg;

      qw = req.quat_w;
      qx = req.quat_x;
      qy = req.quat_y;
      qz = req.quat_z;

      // quaternion products
      s1_prod_in[0] = qw * qw;
      s1_prod_in[1] = qx * qx;
      s1_prod_in[2] = qy * qy;
      s1_prod_in[3] = qz * qz;
      s1_prod_in[4] = qx * qy;
      s1_prod_in[5] = qx * qz;
      s1_prod_in[6] = qy * qz;
      s1_prod_in[7] = qw * qx;
      s1_prod_in[8] = qw * qy;
      s1_prod_in[9] = qw * qz;

      // quarter, truncated toward zero
      for (int i = 0; i < 10; i++) begin
         qtmp = (s1_prod_ff[i] + (s1_prod_ff[i][63] ? 64'sd3 : 64'sd0)) >>> 2;
         s2_qtr_in[i] = qtmp[61:0];
      end

      // norm and numerators
      for (int i = 0; i < 10; i++) begin
         qe[i] = 64'(s2_qtr_ff[i]);
      end
      n64 = qe[0] + qe[1] + qe[2] + qe[3];
      s3_n_in = n64[62:0];
      s3_num_in[0] = qe[0] + qe[1] - qe[2] - qe[3];
      s3_num_in[1] = (qe[4] - qe[9]) <<< 1;
      s3_num_in[2] = (qe[5] + qe[8]) <<< 1;
      s3_num_in[3] = (qe[4] + qe[9]) <<< 1;
      s3_num_in[4] = qe[0] - qe[1] + qe[2] - qe[3];
      s3_num_in[5] = (qe[6] - qe[7]) <<< 1;
      s3_num_in[6] = (qe[5] - qe[8]) <<< 1;
      s3_num_in[7] = (qe[6] + qe[7]) <<< 1;
      s3_num_in[8] = qe[0] - qe[1] - qe[2] + qe[3];

      // magnitude, sign and scale shift
      for (int i = 0; i < 9; i++) begin
         s4_neg_in[i] = s3_num_ff[i][63];
         mag64 = s3_num_ff[i][63] ? -s3_num_ff[i] : s3_num_ff[i];
         s4_mag_in[i] = mag64[62:0];
      end
      s4_k_in = bitlen31(s3_n_ff[62:32]);
      s4_n_in = s3_n_ff;

      // scale down to a 32-bit divisor
      for (int i = 0; i < 9; i++) begin
         shv = s4_mag_ff[i] >> s4_k_ff;
         s5_mag_in[i] = shv[32:0];
      end
      nsh = s4_n_ff >> s4_k_ff;
      s5_den_in  = nsh[31:0];
      s5_neg_in  = s4_neg_ff;
      s5_zero_in = (s4_n_ff == '0);

      // dividend with rounding bias and clamp test
      lim = ({32'b0, s5_den_ff} << 30) + {32'b0, s5_den_ff};
      for (int i = 0; i < 9; i++) begin
         dv_rem_in[0][i]   = ({31'b0, s5_mag_ff[i]} << 30) + {33'b0, s5_den_ff[31:1]};
         dv_quo_in[0][i]   = '0;
         dv_clamp_in[0][i] = (dv_rem_in[0][i] >= lim);
      end
      dv_den_in[0]  = s5_den_ff;
      dv_neg_in[0]  = s5_neg_ff;
      dv_zero_in[0] = s5_zero_ff;

      // one quotient bit per stage
      for (int s = 0; s < wiit_pkg::DIV_BITS; s++) begin
         trial = {32'b0, dv_den_ff[s]} << (wiit_pkg::DIV_BITS - 1 - s);
         for (int i = 0; i < 9; i++) begin
            ge = (dv_rem_ff[s][i] >= trial);
            dv_rem_in[s+1][i] = ge ? (dv_rem_ff[s][i] - trial) : dv_rem_ff[s][i];
            dv_quo_in[s+1][i] = {dv_quo_ff[s][i][wiit_pkg::DIV_BITS-2:0], ge};
         end
         dv_den_in[s+1]   = dv_den_ff[s];
         dv_neg_in[s+1]   = dv_neg_ff[s];
         dv_clamp_in[s+1] = dv_clamp_ff[s];
         dv_zero_in[s+1]  = dv_zero_ff[s];
      end

      // signed, clamped matrix element; identity for a zero quaternion
      for (int i = 0; i < 9; i++) begin
         rmag = dv_clamp_ff[wiit_pkg::DIV_BITS][i] ?
                wiit_pkg::ONE_Q30[wiit_pkg::DIV_BITS-1:0] :
                dv_quo_ff[wiit_pkg::DIV_BITS][i];
         rsg = $signed(32'({1'b0, rmag}));
         if (dv_zero_ff[wiit_pkg::DIV_BITS]) begin
            rot_in[i] = (i == 0 || i == 4 || i == 8) ? wiit_pkg::ONE_Q30 : 32'sd0;
         end else begin
            rot_in[i] = dv_neg_ff[wiit_pkg::DIV_BITS][i] ? -rsg : rsg;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_prod_ff <= s1_prod_in;
         s2_qtr_ff  <= s2_qtr_in;
         s3_n_ff    <= s3_n_in;
         s3_num_ff  <= s3_num_in;
         s4_n_ff    <= s4_n_in;
         s4_k_ff    <= s4_k_in;
         s4_mag_ff  <= s4_mag_in;
         s4_neg_ff  <= s4_neg_in;
         s5_mag_ff  <= s5_mag_in;
         s5_den_ff  <= s5_den_in;
         s5_neg_ff  <= s5_neg_in;
         s5_zero_ff <= s5_zero_in;
         dv_rem_ff   <= dv_rem_in;
         dv_quo_ff   <= dv_quo_in;
         dv_den_ff   <= dv_den_in;
         dv_neg_ff   <= dv_neg_in;
         dv_clamp_ff <= dv_clamp_in;
         dv_zero_ff  <= dv_zero_in;
         rot_ff      <= rot_in;
      end
   end

   assign rot = rot_ff;

endmodule

// ----- hw/rtl/wiit_det.sv -----
// exact zero test of the local tensor determinant, split multiplies
module wiit_det (
   input  logic                      clock,
   input  logic                      adv,
   input  wiit_pkg::wiit_tensor_type ten,
   output logic                      singular
);

   logic signed [63:0] d1_prod_in [6];
   logic signed [63:0] d1_prod_ff [6];
   logic signed [31:0] d1_e_in [3];
   logic signed [31:0] d1_e_ff [3];
   logic signed [64:0] d2_c_in [3];
   logic signed [64:0] d2_c_ff [3];
   logic signed [31:0] d2_e_ff [3];
   logic signed [64:0] d3_lo_in [3];
   logic signed [64:0] d3_lo_ff [3];
   logic signed [64:0] d3_hi_in [3];
   logic signed [64:0] d3_hi_ff [3];
   logic signed [96:0] d4_term_in [3];
   logic signed [96:0] d4_term_ff [3];
   logic               d5_zero_in;
   logic               d5_zero_ff;

   always_comb begin
      logic signed [98:0] det;

      // cofactor products
      d1_prod_in[0] = ten.yy * ten.zz;
      d1_prod_in[1] = ten.yz * ten.yz;
      d1_prod_in[2] = ten.xy * ten.zz;
      d1_prod_in[3] = ten.yz * ten.xz;
      d1_prod_in[4] = ten.xy * ten.yz;
      d1_prod_in[5] = ten.yy * ten.xz;
      d1_e_in[0] = ten.xx;
      d1_e_in[1] = ten.xy;
      d1_e_in[2] = ten.xz;

      for (int t = 0; t < 3; t++) begin
         d2_c_in[t] = 65'(d1_prod_ff[2*t]) - 65'(d1_prod_ff[2*t+1]);
      end

      // low and high halves of each cofactor
      for (int t = 0; t < 3; t++) begin
         d3_lo_in[t] = 65'(d2_e_ff[t]) * $signed({32'b0, 1'b0, d2_c_ff[t][31:0]});
         d3_hi_in[t] = 65'(d2_e_ff[t]) * 65'($signed(d2_c_ff[t][64:32]));
      end

      for (int t = 0; t < 3; t++) begin
         d4_term_in[t] = $signed({d3_hi_ff[t][64:0], 32'b0}) + 97'(d3_lo_ff[t]);
      end

      det = 99'(d4_term_ff[0]) - 99'(d4_term_ff[1]) + 99'(d4_term_ff[2]);
      d5_zero_in = (det == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d1_prod_ff <= d1_prod_in;
         d1_e_ff    <= d1_e_in;
         d2_c_ff    <= d2_c_in;
         d2_e_ff    <= d1_e_ff;
         d3_lo_ff   <= d3_lo_in;
         d3_hi_ff   <= d3_hi_in;
         d4_term_ff <= d4_term_in;
         d5_zero_ff <= d5_zero_in;
      end
   end

   assign singular = d5_zero_ff;

endmodule

// ----- hw/rtl/world_inverse_inertia_transform.sv -----
// top level: world inverse inertia tensor R*L*R^T with singular flag
//
//   channel   direction   handshake                 payload
//   req       in          req_valid / req_stall     wiit_req_type
//   rsp       out         rsp_valid / rsp_stall     wiit_rsp_type
//
// one body enters per cycle while req_stall is low
// latency is set by the 31-stage restoring divider that normalizes the rotation matrix
// synchronous reset clears the valid bits of the pipeline, output register and skid register
// rsp_stall is absorbed by a skid register; req_stall is the registered skid-full bit
// while the skid holds a result the whole pipeline freezes and nothing is lost or repeated
module world_inverse_inertia_transform (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  wiit_pkg::wiit_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output wiit_pkg::wiit_rsp_type rsp_data
);

   logic adv;

   logic [wiit_pkg::PIPE_LAT-1:0] vld_in;
   logic [wiit_pkg::PIPE_LAT-1:0] vld_ff;

   wiit_pkg::wiit_tensor_type ten_req;
   wiit_pkg::wiit_tensor_type ten_in [wiit_pkg::ROT_LAT];
   wiit_pkg::wiit_tensor_type ten_ff [wiit_pkg::ROT_LAT];

   logic signed [31:0] rot [9];
   logic               det_zero;

   logic [wiit_pkg::PIPE_LAT-wiit_pkg::DET_LAT-1:0] sing_in;
   logic [wiit_pkg::PIPE_LAT-wiit_pkg::DET_LAT-1:0] sing_ff;

   logic signed [63:0] mp_in [9][3];
   logic signed [63:0] mp_ff [9][3];
   logic signed [31:0] rot1_ff [9];
   logic signed [33:0] ms_in [9];
   logic signed [33:0] ms_ff [9];
   logic signed [31:0] rot2_ff [9];
   logic signed [63:0] wp_in [6][3];
   logic signed [63:0] wp_ff [6][3];
   logic signed [33:0] wr_in [6][3];
   logic signed [33:0] wr_ff [6][3];
   logic signed [31:0] ws_in [6];
   logic signed [31:0] ws_ff [6];

   wiit_pkg::wiit_rsp_type pipe_rsp;
   logic                   pipe_vld;
   logic                   take;
   logic                   out_vld_in;
   logic                   out_vld_ff;
   wiit_pkg::wiit_rsp_type out_in;
   wiit_pkg::wiit_rsp_type out_ff;
   logic                   skid_vld_in;
   logic                   skid_vld_ff;
   wiit_pkg::wiit_rsp_type skid_in;
   wiit_pkg::wiit_rsp_type skid_ff;

   // divide by 2^30, half away from zero
   function automatic logic signed [33:0] rnd30(input logic signed [63:0] v);
      logic [63:0] mag;
      logic [63:0] q;
      mag = v[63] ? 64'(-v) : 64'(v);
      q = (mag + 64'h2000_0000) >> 30;
      return v[63] ? -$signed({1'b0, q[32:0]}) : $signed({1'b0, q[32:0]});
   endfunction

   assign adv       = !skid_vld_ff;
   assign req_stall = skid_vld_ff;

   always_comb begin
      ten_req.xx = req_data.local_xx;
      ten_req.xy = req_data.local_xy;
      ten_req.xz = req_data.local_xz;
      ten_req.yy = req_data.local_yy;
      ten_req.yz = req_data.local_yz;
      ten_req.zz = req_data.local_zz;
   end

   wiit_rot u_rot (
      .clock (clock),
      .adv   (adv),
      .req   (req_data),
      .rot   (rot)
   );

   wiit_det u_det (
      .clock    (clock),
      .adv      (adv),
      .ten      (ten_req),
      .singular (det_zero)
   );

   always_comb begin
      logic signed [31:0] lf [9];
      logic signed [63:0] sum;
      logic signed [35:0] wsum;
      int                 oi, oj;

      vld_in  = {vld_ff[wiit_pkg::PIPE_LAT-2:0], req_valid};
      sing_in = {sing_ff[wiit_pkg::PIPE_LAT-wiit_pkg::DET_LAT-2:0], det_zero};
      ten_in[0] = ten_req;
      for (int i = 1; i < wiit_pkg::ROT_LAT; i++) begin
         ten_in[i] = ten_ff[i-1];
      end

      // full symmetric local tensor
      lf[0] = ten_ff[wiit_pkg::ROT_LAT-1].xx;
      lf[1] = ten_ff[wiit_pkg::ROT_LAT-1].xy;
      lf[2] = ten_ff[wiit_pkg::ROT_LAT-1].xz;
      lf[3] = ten_ff[wiit_pkg::ROT_LAT-1].xy;
      lf[4] = ten_ff[wiit_pkg::ROT_LAT-1].yy;
      lf[5] = ten_ff[wiit_pkg::ROT_LAT-1].yz;
      lf[6] = ten_ff[wiit_pkg::ROT_LAT-1].xz;
      lf[7] = ten_ff[wiit_pkg::ROT_LAT-1].yz;
      lf[8] = ten_ff[wiit_pkg::ROT_LAT-1].zz;

      // m = l * r^t
      for (int a = 0; a < 3; a++) begin
         for (int j = 0; j < 3; j++) begin
            for (int b = 0; b < 3; b++) begin
               mp_in[a*3+j][b] = lf[a*3+b] * rot[j*3+b];
            end
         end
      end
      for (int e = 0; e < 9; e++) begin
         sum = mp_ff[e][0] + mp_ff[e][1] + mp_ff[e][2];
         ms_in[e] = rnd30(sum);
      end

      // w = r * m, upper triangle
      for (int o = 0; o < 6; o++) begin
         oi = (o < 3) ? 0 : ((o < 5) ? 1 : 2);
         oj = (o < 3) ? o : ((o < 5) ? o - 2 : 2);
         for (int a = 0; a < 3; a++) begin
            wp_in[o][a] = rot2_ff[oi*3+a] * ms_ff[a*3+oj];
            wr_in[o][a] = rnd30(wp_ff[o][a]);
         end
         wsum = 36'(wr_ff[o][0]) + 36'(wr_ff[o][1]) + 36'(wr_ff[o][2]);
         if (wsum > 36'sd2147483647) begin
            ws_in[o] = 32'sh7fff_ffff;
         end else if (wsum < -36'sd2147483648) begin
            ws_in[o] = 32'sh8000_0000;
         end else begin
            ws_in[o] = wsum[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sing_ff <= sing_in;
         ten_ff  <= ten_in;
         mp_ff   <= mp_in;
         rot1_ff <= rot;
         ms_ff   <= ms_in;
         rot2_ff <= rot1_ff;
         wp_ff   <= wp_in;
         wr_ff   <= wr_in;
         ws_ff   <= ws_in;
      end
   end

   // output register and skid
   always_comb begin
      pipe_rsp.world_xx      = ws_ff[0];
      pipe_rsp.world_xy      = ws_ff[1];
      pipe_rsp.world_xz      = ws_ff[2];
      pipe_rsp.world_yy      = ws_ff[3];
      pipe_rsp.world_yz      = ws_ff[4];
      pipe_rsp.world_zz      = ws_ff[5];
      pipe_rsp.singular_flag = sing_ff[wiit_pkg::PIPE_LAT-wiit_pkg::DET_LAT-1];

      take     = out_vld_ff && !rsp_stall;
      pipe_vld = vld_ff[wiit_pkg::PIPE_LAT-1] && adv;

      out_vld_in  = out_vld_ff;
      out_in      = out_ff;
      skid_vld_in = skid_vld_ff;
      skid_in     = skid_ff;
      if (!out_vld_ff || take) begin
         if (skid_vld_ff) begin
            out_vld_in  = 1'b1;
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end else begin
            out_vld_in = pipe_vld;
            out_in     = pipe_rsp;
         end
      end else if (pipe_vld) begin
         skid_vld_in = 1'b1;
         skid_in     = pipe_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid holds a result while the output register is empty");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_vld_ff) |-> $past(out_vld_ff && rsp_stall))
      else $error("skid filled without a stalled output");

   a_pipe_frozen: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |=> $stable(vld_ff))
      else $error("pipeline moved while the skid was full");

   a_skid_refill: assert property (@(posedge clock) disable iff (reset)
      (skid_vld_ff && take) |=> rsp_valid)
      else $error("skid result not moved to the output after a transfer");

endmodule

// ----- verif/world_inverse_inertia_transform_test.sv -----
// testbench for the world inverse inertia transform: directed and random bodies
module world_inverse_inertia_transform_test;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   wiit_pkg::wiit_req_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   wiit_pkg::wiit_rsp_type rsp_data;

   wiit_pkg::wiit_rsp_type world_queue[$];
   bit                     calm = 1'b0;
   int                     errors = 0;

   world_inverse_inertia_transform i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic longint round_away(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic wiit_pkg::wiit_rsp_type world_tensor(wiit_pkg::wiit_req_type b);
      longint lt[9];
      longint rot[9];
      longint mt[9];
      longint nm[9];
      longint w, x, y, z, ww, xx, yy, zz, xy, xz, yz, wx, wy, wz, n, d, s, r;
      logic signed [127:0] e[9];
      logic signed [127:0] det;
      logic signed [31:0] res[6];
      int ri[6] = '{0, 0, 0, 1, 1, 2};
      int cj[6] = '{0, 1, 2, 1, 2, 2};
      wiit_pkg::wiit_rsp_type o;
      w = b.quat_w; x = b.quat_x; y = b.quat_y; z = b.quat_z;
      lt[0] = b.local_xx; lt[1] = b.local_xy; lt[2] = b.local_xz;
      lt[3] = b.local_xy; lt[4] = b.local_yy; lt[5] = b.local_yz;
      lt[6] = b.local_xz; lt[7] = b.local_yz; lt[8] = b.local_zz;
      ww = (w * w) / 4; xx = (x * x) / 4; yy = (y * y) / 4; zz = (z * z) / 4;
      xy = (x * y) / 4; xz = (x * z) / 4; yz = (y * z) / 4;
      wx = (w * x) / 4; wy = (w * y) / 4; wz = (w * z) / 4;
      n = ww + xx + yy + zz;
      if (n == 0) begin
         for (int i = 0; i < 9; i++) rot[i] = (i % 4 == 0) ? 64'sd1073741824 : 0;
      end else begin
         nm[0] = ww + xx - yy - zz;
         nm[1] = 2 * (xy - wz);
         nm[2] = 2 * (xz + wy);
         nm[3] = 2 * (xy + wz);
         nm[4] = ww - xx + yy - zz;
         nm[5] = 2 * (yz - wx);
         nm[6] = 2 * (xz - wy);
         nm[7] = 2 * (yz + wx);
         nm[8] = ww - xx - yy + zz;
         d = 1;
         for (int k = 0; k < 40 && (n / d) >= 64'sd4294967296; k++) d = d * 2;
         n = n / d;
         for (int i = 0; i < 9; i++) begin
            r = round_away((nm[i] / d) * 64'sd1073741824, n);
            if (r > 64'sd1073741824) r = 64'sd1073741824;
            if (r < -64'sd1073741824) r = -64'sd1073741824;
            rot[i] = r;
         end
      end
      for (int a = 0; a < 3; a++)
         for (int j = 0; j < 3; j++)
            mt[a*3+j] = round_away(lt[a*3] * rot[j*3] + lt[a*3+1] * rot[j*3+1]
                                   + lt[a*3+2] * rot[j*3+2], 64'sd1073741824);
      for (int f = 0; f < 6; f++) begin
         s = 0;
         for (int a = 0; a < 3; a++)
            s += round_away(rot[ri[f]*3+a] * mt[a*3+cj[f]], 64'sd1073741824);
         if (s > 64'sd2147483647) s = 64'sd2147483647;
         if (s < -64'sd2147483648) s = -64'sd2147483648;
         res[f] = s[31:0];
      end
      for (int i = 0; i < 9; i++) e[i] = lt[i];
      det = e[0] * (e[4] * e[8] - e[5] * e[7]) - e[1] * (e[3] * e[8] - e[5] * e[6])
          + e[2] * (e[3] * e[7] - e[4] * e[6]);
      o.world_xx = res[0]; o.world_xy = res[1]; o.world_xz = res[2];
      o.world_yy = res[3]; o.world_yz = res[4]; o.world_zz = res[5];
      o.singular_flag = (det == 0);
      return o;
   endfunction

   task automatic send_body(wiit_pkg::wiit_req_type b);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      do @(posedge clock); while (req_stall);
      world_queue.push_back(world_tensor(b));
   endtask

   // rsp side backpressure in bursts
   initial begin
      forever begin
         if (!calm && !reset && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (world_queue.size() == 0) begin
            $display("%0t: unexpected transfer, actual %h", $realtime, rsp_data);
            errors++;
         end else begin
            automatic wiit_pkg::wiit_rsp_type want = world_queue.pop_front();
            automatic logic [192:0] wb = want;
            automatic logic [192:0] gb = rsp_data;
            for (int f = 0; f < 6; f++)
               if (wb[192-32*f -: 32] !== gb[192-32*f -: 32]) begin
                  $display("%0t: element %0d expected %h actual %h", $realtime, f,
                           wb[192-32*f -: 32], gb[192-32*f -: 32]);
                  errors++;
               end
            if (wb[0] !== gb[0]) begin
               $display("%0t: singular flag expected %b actual %b", $realtime, wb[0], gb[0]);
               errors++;
            end
         end
      end
   end

   function automatic wiit_pkg::wiit_req_type body(int w, int x, int y, int z, int a, int b,
                                                   int c, int d, int e, int f);
      wiit_pkg::wiit_req_type r;
      r.quat_w = w; r.quat_x = x; r.quat_y = y; r.quat_z = z;
      r.local_xx = a; r.local_xy = b; r.local_xz = c;
      r.local_yy = d; r.local_yz = e; r.local_zz = f;
      return r;
   endfunction

   function automatic int any32();
      return int'($urandom());
   endfunction

   function automatic int quat_part(int mode);
      case (mode)
         0: return any32();
         1: return $urandom_range(0, 6) - 3;
         default: return int'($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
      endcase
   endfunction

   function automatic int c_rand();
      return quat_part(2);
   endfunction

   task automatic test_rotations;
      int c45 = 759250125;
      send_body(body(32'sh4000_0000, 0, 0, 0, 65536, 100, -200, 131072, 300, 196608));
      send_body(body(0, 0, 0, 0, 65536, 100, -200, 131072, 300, 196608));
      send_body(body(1, -1, 1, 1, 65536, 5, 6, 65536, 7, 65536));
      send_body(body(c45, 0, 0, c45, 65536, 0, 0, 131072, 0, 196608));
      send_body(body(c45, c45, 0, 0, 65536, 1000, 0, 131072, 0, 196608));
      send_body(body(0, 32'sh4000_0000, 0, 0, 65536, 1, 2, 65536, 3, 65536));
      send_body(body(3, 4, 5, 6, 70000, -50, 40, 80000, 30, 90000));
      send_body(body(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                     65536, 1, 2, 3, 4, 5));
      send_body(body(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                     -1, -1, -1, -1, -1, -1));
      send_body(body(32'sh7fff_ffff, 0, 0, 0, 32'sh7fff_ffff, 0, 0, 32'sh7fff_ffff, 0,
                     32'sh7fff_ffff));
   endtask

   task automatic test_singular;
      send_body(body(32'sh4000_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_body(body(c_rand(), c_rand(), c_rand(), c_rand(), 0, 0, 0, 65536, 10, 65536));
      send_body(body(c_rand(), 1000, 0, 0, 4, 6, 8, 9, 12, 16));
      send_body(body(500, 0, 700, 0, 65536, 65536, 0, 65536, 0, 131072));
   endtask

   task automatic test_saturation;
      int c45 = 759250125;
      send_body(body(c45, 0, 0, c45, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, 32'sh7fff_ffff, 0, 0));
      send_body(body(c45, 0, 0, c45, 32'sh8000_0000, 32'sh8000_0000, 0, 32'sh8000_0000, 0,
                     32'sh8000_0000));
      send_body(body(c45, c45, c45, c45, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                     32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
      send_body(body(c45, -c45, c45, -c45, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                     32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000));
   endtask

   task automatic test_random_bodies(int count);
      wiit_pkg::wiit_req_type b;
      int qm, sa, sb, sc;
      for (int n = 0; n < count; n++) begin
         if (n > count - 80) calm = 1'b1;
         qm = ($urandom_range(0, 9) == 0) ? 1 : ($urandom_range(0, 3) == 0 ? 0 : 2);
         b.quat_w = quat_part(qm); b.quat_x = quat_part(qm);
         b.quat_y = quat_part(qm); b.quat_z = quat_part(qm);
         case ($urandom_range(0, 5))
            0, 1: begin
               b.local_xx = any32(); b.local_xy = any32(); b.local_xz = any32();
               b.local_yy = any32(); b.local_yz = any32(); b.local_zz = any32();
            end
            2: begin
               sa = $urandom_range(0, 2000) - 1000;
               sb = $urandom_range(0, 2000) - 1000;
               sc = $urandom_range(0, 2000) - 1000;
               b.local_xx = sa * sa; b.local_xy = sa * sb; b.local_xz = sa * sc;
               b.local_yy = sb * sb; b.local_yz = sb * sc; b.local_zz = sc * sc;
            end
            default: begin
               b.local_xx = $urandom_range(1, 1 << 22);
               b.local_yy = $urandom_range(1, 1 << 22);
               b.local_zz = $urandom_range(1, 1 << 22);
               b.local_xy = $urandom_range(0, 1 << 16) - (1 << 15);
               b.local_xz = $urandom_range(0, 1 << 16) - (1 << 15);
               b.local_yz = $urandom_range(0, 1 << 16) - (1 << 15);
            end
         endcase
         send_body(b);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_rotations();
      test_singular();
      test_saturation();
      test_random_bodies(700);
      req_valid <= 1'b0;
      while (world_queue.size() != 0) @(posedge clock);
      repeat (wiit_pkg::PIPE_LAT + wiit_pkg::DET_LAT + 10) @(posedge clock);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
